// File: hw/rtl/tchl_pkg.sv
package tchl_pkg;

  localparam int unsigned TILE_W    = 15;
  localparam int unsigned KEY_W     = 16;
  localparam int unsigned SLOT_OUT_W = 10;
  localparam int unsigned OUTCOME_W = 2;

  localparam logic [KEY_W-1:0] KEY_BLANK = 16'hFFFF;

  localparam logic [OUTCOME_W-1:0] OUTCOME_HIT      = 2'd0;
  localparam logic [OUTCOME_W-1:0] OUTCOME_INSERTED = 2'd1;
  localparam logic [OUTCOME_W-1:0] OUTCOME_FULL     = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_PROBE,
    ST_DONE
  } state_t;

endpackage

// File: hw/rtl/tchl_key_ram.sv
module tchl_key_ram #(
  parameter int unsigned DEPTH  = 1021,
  parameter int unsigned ADDR_W = 10,
  parameter int unsigned DATA_W = 16
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: hw/rtl/tchl_home.sv
module tchl_home #(
  parameter int unsigned TABLE_SLOTS = 1021,
  parameter int unsigned SLOT_W      = 10
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [tchl_pkg::TILE_W-1:0]   tile_id,
  output logic                          home_valid,
  output logic [SLOT_W-1:0]             home
);

  // floor reciprocal: estimated quotient is exact or one low
  localparam logic [63:0] RECIP_W = (64'd1 << 32) / TABLE_SLOTS;
  localparam logic [31:0] RECIP   = RECIP_W[31:0];
  localparam logic [SLOT_W:0] N_C = (SLOT_W+1)'(TABLE_SLOTS);
  localparam int unsigned PROD_W  = tchl_pkg::TILE_W + 32;

  logic                        v1_r, v2_r;
  logic [PROD_W-1:0]           prod_r;
  logic [tchl_pkg::TILE_W-1:0] id1_r;
  logic [SLOT_W:0]             rem_r;
  logic [tchl_pkg::TILE_W-1:0] quot;
  logic [30:0]                 qn;
  logic [15:0]                 diff;

  assign quot = prod_r[PROD_W-1:32];
  assign qn   = quot * 16'(TABLE_SLOTS);
  assign diff = 16'(id1_r) - qn[15:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= start;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(tile_id) * PROD_W'(RECIP);
    id1_r  <= tile_id;
    rem_r  <= diff[SLOT_W:0];
  end

  // remainder estimate lies below twice the slot count
  always_comb begin
    if (rem_r >= N_C) begin
      home = SLOT_W'(rem_r - N_C);
    end else begin
      home = rem_r[SLOT_W-1:0];
    end
  end

  assign home_valid = v2_r;

endmodule

// File: hw/rtl/tile_cache_hash_lookup_insert.sv
// an item goes from the input transfer through the home pipeline, a probe walk over 1..TABLE_SLOTS
// slots and the result and output registers to out_tvalid; one item in flight, the probe walk reads
//   one key per cycle from the single read port of the key memory
// a finished result waits in the output register while the next item is taken
// reset: synchronous active-low rst_n; afterwards a clearing pass writes blank to all
//   TABLE_SLOTS entries before the first input transfer
module tile_cache_hash_lookup_insert #(
  parameter int unsigned TABLE_SLOTS = 1021
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [14:0] tile_id
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [9:0] slot, [11:10] outcome
);

  localparam int unsigned SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int unsigned CNT_W  = $clog2(TABLE_SLOTS + 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);
  localparam logic [CNT_W-1:0]  LAST_PROBE = CNT_W'(TABLE_SLOTS - 1);

  tchl_pkg::state_t state_r, state_nxt;

  logic [SLOT_W-1:0]                  clr_cnt_r, clr_cnt_nxt;
  logic [tchl_pkg::TILE_W-1:0]        id_r, id_nxt;
  logic [SLOT_W-1:0]                  pos_r, pos_nxt;
  logic [CNT_W-1:0]                   probes_r, probes_nxt;
  logic [tchl_pkg::SLOT_OUT_W-1:0]    res_slot_r, res_slot_nxt;
  logic [tchl_pkg::OUTCOME_W-1:0]     res_outcome_r, res_outcome_nxt;
  logic                               out_valid_r, out_valid_nxt;
  logic [tchl_pkg::SLOT_OUT_W-1:0]    out_slot_r, out_slot_nxt;
  logic [tchl_pkg::OUTCOME_W-1:0]     out_outcome_r, out_outcome_nxt;

  logic                               in_xfer;
  logic                               home_valid;
  logic [SLOT_W-1:0]                  home;
  logic [SLOT_W-1:0]                  pos_step;
  logic                               key_hit, key_blank, probe_last;
  logic                               out_free;

  logic                               wr_en;
  logic [SLOT_W-1:0]                  wr_addr;
  logic [tchl_pkg::KEY_W-1:0]         wr_data;
  logic                               rd_en;
  logic [SLOT_W-1:0]                  rd_addr;
  logic [tchl_pkg::KEY_W-1:0]         rd_data;

  // home slot: tile_id modulo the slot count, two pipeline stages
  tchl_home #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .SLOT_W      (SLOT_W)
  ) u_home (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (in_xfer),
    .tile_id    (in_tdata[tchl_pkg::TILE_W-1:0]),
    .home_valid (home_valid),
    .home       (home)
  );

  // key table, one write port and one registered read port
  tchl_key_ram #(
    .DEPTH  (TABLE_SLOTS),
    .ADDR_W (SLOT_W),
    .DATA_W (tchl_pkg::KEY_W)
  ) u_keys (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_xfer    = in_tvalid && in_tready;
  assign pos_step   = (pos_r == LAST_SLOT) ? '0 : pos_r + 1'b1;
  // a 15-bit id never matches the blank code
  assign key_hit    = (rd_data == {1'b0, id_r});
  assign key_blank  = (rd_data == tchl_pkg::KEY_BLANK);
  assign probe_last = (probes_r == LAST_PROBE);
  assign out_free   = !out_valid_r || out_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tchl_pkg::ST_CLEAR: begin
        if (clr_cnt_r == LAST_SLOT) begin
          state_nxt = tchl_pkg::ST_IDLE;
        end
      end
      tchl_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = tchl_pkg::ST_HASH;
        end
      end
      tchl_pkg::ST_HASH: begin
        if (home_valid) begin
          state_nxt = tchl_pkg::ST_PROBE;
        end
      end
      tchl_pkg::ST_PROBE: begin
        if (key_hit || key_blank || probe_last) begin
          state_nxt = tchl_pkg::ST_DONE;
        end
      end
      tchl_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = tchl_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tchl_pkg::ST_CLEAR;
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_tready       = 1'b0;
    wr_en           = 1'b0;
    wr_addr         = pos_r;
    wr_data         = {1'b0, id_r};
    rd_en           = 1'b0;
    rd_addr         = pos_step;
    clr_cnt_nxt     = clr_cnt_r;
    id_nxt          = id_r;
    pos_nxt         = pos_r;
    probes_nxt      = probes_r;
    res_slot_nxt    = res_slot_r;
    res_outcome_nxt = res_outcome_r;
    out_slot_nxt    = out_slot_r;
    out_outcome_nxt = out_outcome_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    unique case (state_r)
      tchl_pkg::ST_CLEAR: begin
        wr_en       = 1'b1;
        wr_addr     = clr_cnt_r;
        wr_data     = tchl_pkg::KEY_BLANK;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
      end
      tchl_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        id_nxt    = in_tdata[tchl_pkg::TILE_W-1:0];
      end
      tchl_pkg::ST_HASH: begin
        // first probe read goes out at the home slot
        rd_en      = home_valid;
        rd_addr    = home;
        pos_nxt    = home;
        probes_nxt = '0;
      end
      tchl_pkg::ST_PROBE: begin
        if (key_hit) begin
          res_slot_nxt    = tchl_pkg::SLOT_OUT_W'(pos_r);
          res_outcome_nxt = tchl_pkg::OUTCOME_HIT;
        end else if (key_blank) begin
          // claim the blank slot
          wr_en           = 1'b1;
          res_slot_nxt    = tchl_pkg::SLOT_OUT_W'(pos_r);
          res_outcome_nxt = tchl_pkg::OUTCOME_INSERTED;
        end else if (probe_last) begin
          res_slot_nxt    = '0;
          res_outcome_nxt = tchl_pkg::OUTCOME_FULL;
        end else begin
          // read the next slot while this one is checked; never the slot written
          rd_en      = 1'b1;
          pos_nxt    = pos_step;
          probes_nxt = probes_r + 1'b1;
        end
      end
      tchl_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_slot_nxt    = res_slot_r;
          out_outcome_nxt = res_outcome_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tchl_pkg::ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r          <= id_nxt;
    pos_r         <= pos_nxt;
    probes_r      <= probes_nxt;
    res_slot_r    <= res_slot_nxt;
    res_outcome_r <= res_outcome_nxt;
    out_slot_r    <= out_slot_nxt;
    out_outcome_r <= out_outcome_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_outcome_r, out_slot_r};

endmodule
